@@ rtl/agsr_pkg.sv @@
// Shared types and constants for the analog game-pad serial responder.
// Depends on nothing; used by agsr_engine and the top level.
`timescale 1ns / 1ps
`default_nettype none
package agsr_pkg;

    localparam int FRAME_DEPTH = 8;

    typedef logic [7:0] byte_t;
    typedef logic [FRAME_DEPTH-1:0][7:0] frame_t;

    // host commands
    localparam byte_t CMD_READ        = 8'h42;
    localparam byte_t CMD_CONFIG      = 8'h43;
    localparam byte_t CMD_SET_MODE    = 8'h44;
    localparam byte_t CMD_MODEL_INFO  = 8'h45;
    localparam byte_t CMD_ACT_INFO    = 8'h46;
    localparam byte_t CMD_COMB_INFO   = 8'h47;
    localparam byte_t CMD_TYPE_INFO   = 8'h4C;
    localparam byte_t CMD_VIB_MAP     = 8'h4D;

    localparam byte_t ID_ANALOG   = 8'h73;
    localparam byte_t ID_DIGITAL  = 8'h41;
    localparam byte_t ANS_CONFIG  = 8'hF3;
    localparam byte_t ANS_IDLE    = 8'hFF;
    localparam byte_t SLOT_NONE   = 8'hFF;

    localparam logic [3:0] DIGITAL_LEN = 4'd4;

    // entry 0 sits in the low byte
    localparam frame_t TAB_ZERO  = 64'h0000_0000_0000_5AFF;
    localparam frame_t TAB_MODEL = 64'h0001_0201_0201_5AFF;
    localparam frame_t TAB_ACT   = 64'h0A00_0201_0000_5AFF;
    localparam frame_t TAB_COMB  = 64'h0001_0002_0000_5AFF;
    localparam frame_t TAB_VIB   = 64'hFFFF_FFFF_FFFF_5AFF;
    localparam frame_t TAB_RESET = 64'h8080_8080_FFFF_5AFF;

    // configuration register indexes
    localparam logic [1:0] REG_IS_ANALOG = 2'd0;
    localparam logic [1:0] REG_STD_TYPE  = 2'd1;
    localparam logic [1:0] REG_ANA_TYPE  = 2'd2;

    typedef struct packed {
        logic        req_type;
        byte_t       tx_byte;
        logic [15:0] buttons;
        byte_t       right_x;
        byte_t       right_y;
        byte_t       left_x;
        byte_t       left_y;
    } item_t;

    typedef struct packed {
        byte_t rx_byte;
        byte_t motor_level_a;
        byte_t motor_level_b;
    } result_t;

    typedef struct packed {
        logic  controller_is_analog;
        byte_t standard_type_code;
        byte_t analog_type_code;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/agsr_engine.sv @@
// Protocol state and single-pass decode of one byte exchange.
// Depends on agsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module agsr_engine #(
    parameter int FRAME_BYTES = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire agsr_pkg::item_t item,
    input  wire agsr_pkg::cfg_t  cfg,
    output agsr_pkg::result_t    result
);

    localparam logic [3:0] FRAME_LEN = 4'(FRAME_BYTES);

    logic [3:0]            byte_index_reg, byte_index_next;
    logic [3:0]            frame_length_reg, frame_length_next;
    agsr_pkg::byte_t       active_command_reg, active_command_next;
    agsr_pkg::frame_t      reply_frame_reg, reply_frame_next;
    agsr_pkg::byte_t       analog_mode_reg, analog_mode_next;
    agsr_pkg::byte_t       pad_id_reg, pad_id_next;
    agsr_pkg::byte_t       config_mode_reg, config_mode_next;
    agsr_pkg::byte_t [1:0] motor_slot_reg, motor_slot_next;
    agsr_pkg::byte_t [1:0] motor_level_reg, motor_level_next;

    agsr_pkg::byte_t rx;
    agsr_pkg::byte_t cmd;
    logic            use_data;
    logic [2:0]      ix;
    logic [2:0]      idx_m1;
    logic [1:0]      half;
    agsr_pkg::byte_t idx_byte;

    always_comb begin
        byte_index_next   = byte_index_reg;
        frame_length_next = frame_length_reg;
        active_command_next = active_command_reg;
        reply_frame_next  = reply_frame_reg;
        analog_mode_next  = analog_mode_reg;
        pad_id_next       = pad_id_reg;
        config_mode_next  = config_mode_reg;
        motor_slot_next   = motor_slot_reg;
        motor_level_next  = motor_level_reg;
        rx       = agsr_pkg::ANS_IDLE;
        cmd      = cfg.controller_is_analog ? item.tx_byte : agsr_pkg::CMD_READ;
        use_data = 1'b0;
        ix       = byte_index_reg[2:0];
        idx_byte = {4'd0, byte_index_reg};
        idx_m1   = ix - 3'd1;
        half     = idx_m1[2:1];

        if (!item.req_type) begin
            byte_index_next = 4'd0;
        end else if (byte_index_reg == 4'd0) begin
            // first byte: latch command, load frame
            active_command_next = cmd;
            byte_index_next     = 4'd1;
            frame_length_next   = FRAME_LEN;
            rx                  = agsr_pkg::ANS_CONFIG;
            case (cmd)
                agsr_pkg::CMD_SET_MODE:   reply_frame_next = agsr_pkg::TAB_ZERO;
                agsr_pkg::CMD_MODEL_INFO: begin
                    reply_frame_next    = agsr_pkg::TAB_MODEL;
                    reply_frame_next[4] = analog_mode_reg;
                end
                agsr_pkg::CMD_ACT_INFO:   reply_frame_next = agsr_pkg::TAB_ACT;
                agsr_pkg::CMD_COMB_INFO:  reply_frame_next = agsr_pkg::TAB_COMB;
                agsr_pkg::CMD_TYPE_INFO:  reply_frame_next = agsr_pkg::TAB_ZERO;
                agsr_pkg::CMD_VIB_MAP:    reply_frame_next = agsr_pkg::TAB_VIB;
                agsr_pkg::CMD_CONFIG: begin
                    if (config_mode_reg != 8'd0) begin
                        reply_frame_next = agsr_pkg::TAB_ZERO;
                    end else begin
                        use_data = 1'b1;
                    end
                end
                default: use_data = 1'b1;
            endcase
            if (use_data) begin
                reply_frame_next[2] = item.buttons[7:0];
                reply_frame_next[3] = item.buttons[15:8];
                if (analog_mode_reg == 8'd1) begin
                    reply_frame_next[4] = item.right_x;
                    reply_frame_next[5] = item.right_y;
                    reply_frame_next[6] = item.left_x;
                    reply_frame_next[7] = item.left_y;
                end else begin
                    frame_length_next = agsr_pkg::DIGITAL_LEN;
                end
                rx = pad_id_reg;
            end
        end else if (byte_index_reg >= frame_length_reg || byte_index_reg > 4'd7) begin
            rx = agsr_pkg::ANS_IDLE;
        end else begin
            if (byte_index_reg == 4'd2) begin
                case (active_command_reg)
                    agsr_pkg::CMD_CONFIG: config_mode_next = item.tx_byte;
                    agsr_pkg::CMD_SET_MODE: begin
                        analog_mode_next = item.tx_byte;
                        pad_id_next = (item.tx_byte != 8'd0) ? agsr_pkg::ID_ANALOG
                                                             : agsr_pkg::ID_DIGITAL;
                    end
                    agsr_pkg::CMD_ACT_INFO: begin
                        if (item.tx_byte == 8'd0) begin
                            reply_frame_next[5] = 8'h02;
                            reply_frame_next[6] = 8'h00;
                            reply_frame_next[7] = 8'h0A;
                        end else if (item.tx_byte == 8'd1) begin
                            reply_frame_next[5] = 8'h01;
                            reply_frame_next[6] = 8'h01;
                            reply_frame_next[7] = 8'h14;
                        end
                    end
                    agsr_pkg::CMD_TYPE_INFO: begin
                        if (item.tx_byte == 8'd0) begin
                            reply_frame_next[5] = cfg.standard_type_code;
                        end else if (item.tx_byte == 8'd1) begin
                            reply_frame_next[5] = cfg.analog_type_code;
                        end
                    end
                    default: ;
                endcase
            end
            if (cfg.controller_is_analog) begin
                if (active_command_reg == agsr_pkg::CMD_READ) begin
                    for (int i = 0; i < 2; i++) begin
                        if (motor_slot_reg[i] == idx_byte) motor_level_next[i] = item.tx_byte;
                    end
                end else if (active_command_reg == agsr_pkg::CMD_VIB_MAP) begin
                    for (int i = 0; i < 2; i++) begin
                        if (motor_slot_reg[i] == idx_byte) reply_frame_next[ix] = 8'd0;
                    end
                    if (item.tx_byte < 8'd2) begin
                        motor_slot_next[item.tx_byte[0]] = idx_byte;
                        if (pad_id_reg[3:0] < {2'd0, half}) begin
                            pad_id_next = {pad_id_reg[7:4], 2'd0, half};
                        end
                    end
                end
            end
            rx              = reply_frame_next[ix];
            byte_index_next = byte_index_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg     <= 4'd0;
            frame_length_reg   <= 4'd0;
            active_command_reg <= 8'd0;
            reply_frame_reg    <= agsr_pkg::TAB_RESET;
            analog_mode_reg    <= 8'd1;
            pad_id_reg         <= agsr_pkg::ID_ANALOG;
            config_mode_reg    <= 8'd0;
            motor_slot_reg     <= {agsr_pkg::SLOT_NONE, agsr_pkg::SLOT_NONE};
            motor_level_reg    <= '0;
        end else if (step_en) begin
            byte_index_reg     <= byte_index_next;
            frame_length_reg   <= frame_length_next;
            active_command_reg <= active_command_next;
            reply_frame_reg    <= reply_frame_next;
            analog_mode_reg    <= analog_mode_next;
            pad_id_reg         <= pad_id_next;
            config_mode_reg    <= config_mode_next;
            motor_slot_reg     <= motor_slot_next;
            motor_level_reg    <= motor_level_next;
        end
    end

    assign result.rx_byte       = rx;
    assign result.motor_level_a = motor_level_next[0];
    assign result.motor_level_b = motor_level_next[1];

    // index stops one past the last frame byte
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg <= 4'd8)
        else $error("byte index ran past frame");

    // a mapped slot always names a data byte position
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (motor_slot_reg[0] == agsr_pkg::SLOT_NONE ||
         (motor_slot_reg[0] != 8'd0 && motor_slot_reg[0] < 8'd8)) &&
        (motor_slot_reg[1] == agsr_pkg::SLOT_NONE ||
         (motor_slot_reg[1] != 8'd0 && motor_slot_reg[1] < 8'd8)))
        else $error("motor slot out of range");

    // frame length is unset, the short digital read or the full frame
    a_len_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_length_reg == 4'd0 || frame_length_reg == agsr_pkg::DIGITAL_LEN ||
        frame_length_reg == FRAME_LEN)
        else $error("frame length out of range");

endmodule
`default_nettype wire

@@ rtl/analog_gamepad_serial_responder.sv @@
// An accepted item is held in the item register, then its decode result in the result register.
// Throughput: one item per cycle while m_ready is high; decode is a single pass through agsr_engine.
// Configuration registers written through cfg_we/cfg_index/cfg_wdata, no read-back.
// Reset (aresetn low, synchronous): both stages empty, registers to defaults
// (analog pad, type codes 4 and 7), pad state to power-on frame and id 0x73.
`timescale 1ns / 1ps
`default_nettype none
module analog_gamepad_serial_responder #(
    parameter int FRAME_BYTES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_tx_byte,
    input  wire logic [15:0] s_buttons,
    input  wire logic [7:0]  s_right_x,
    input  wire logic [7:0]  s_right_y,
    input  wire logic [7:0]  s_left_x,
    input  wire logic [7:0]  s_left_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_rx_byte,
    output logic [7:0]       m_motor_level_a,
    output logic [7:0]       m_motor_level_b
);

    agsr_pkg::cfg_t    cfg_reg;
    agsr_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    agsr_pkg::result_t out_reg;
    logic              out_valid_reg;
    agsr_pkg::result_t result;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.controller_is_analog <= 1'b1;
            cfg_reg.standard_type_code   <= 8'd4;
            cfg_reg.analog_type_code     <= 8'd7;
        end else if (cfg_we) begin
            case (cfg_index)
                agsr_pkg::REG_IS_ANALOG: cfg_reg.controller_is_analog <= cfg_wdata[0];
                agsr_pkg::REG_STD_TYPE:  cfg_reg.standard_type_code   <= cfg_wdata;
                agsr_pkg::REG_ANA_TYPE:  cfg_reg.analog_type_code     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{req_type: s_req_type, tx_byte: s_tx_byte,
                             buttons: s_buttons, right_x: s_right_x,
                             right_y: s_right_y, left_x: s_left_x, left_y: s_left_y};
        end
    end

    agsr_engine #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_rx_byte       = out_reg.rx_byte;
    assign m_motor_level_a = out_reg.motor_level_a;
    assign m_motor_level_b = out_reg.motor_level_b;

    // an empty result stage never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

    // a held item moves on as soon as the result stage is free
    a_item_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("item not passed to result stage");

    // an accepted item is held in the input stage
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item lost");

endmodule
`default_nettype wire

@@ sim/tb_analog_gamepad_serial_responder.sv @@
// Self-checking testbench for analog_gamepad_serial_responder: poll frames with
// random idling on both channels, checked against a cycle-free model of the pad.
// Depends on rtl/agsr_pkg.sv and rtl/analog_gamepad_serial_responder.sv.
`timescale 1ns / 1ps
module tb_analog_gamepad_serial_responder;

    localparam int FRAME_BYTES = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 130;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = agsr_pkg::REG_IS_ANALOG;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [7:0]  s_tx_byte = 8'h00;
    logic [15:0] s_buttons = 16'h0000;
    logic [7:0]  s_right_x = 8'h00;
    logic [7:0]  s_right_y = 8'h00;
    logic [7:0]  s_left_x = 8'h00;
    logic [7:0]  s_left_y = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_rx_byte;
    logic [7:0]  m_motor_level_a;
    logic [7:0]  m_motor_level_b;

    analog_gamepad_serial_responder #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_tx_byte      (s_tx_byte),
        .s_buttons      (s_buttons),
        .s_right_x      (s_right_x),
        .s_right_y      (s_right_y),
        .s_left_x       (s_left_x),
        .s_left_y       (s_left_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rx_byte      (m_rx_byte),
        .m_motor_level_a(m_motor_level_a),
        .m_motor_level_b(m_motor_level_b)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // pad model state, reset values
    agsr_pkg::cfg_t   regs = '{controller_is_analog: 1'b1, standard_type_code: 8'h04,
                               analog_type_code: 8'h07};
    logic [3:0]       pad_pos = 4'd0;
    logic [3:0]       pad_len = 4'd0;
    agsr_pkg::byte_t  pad_cmd = 8'h00;
    agsr_pkg::frame_t pad_frame = agsr_pkg::TAB_RESET;
    agsr_pkg::byte_t  pad_analog = 8'h01;
    agsr_pkg::byte_t  pad_ident = agsr_pkg::ID_ANALOG;
    agsr_pkg::byte_t  pad_cfg_mode = 8'h00;
    agsr_pkg::byte_t  motor_slot [2] = '{agsr_pkg::SLOT_NONE, agsr_pkg::SLOT_NONE};
    agsr_pkg::byte_t  motor_lvl [2] = '{8'h00, 8'h00};

    agsr_pkg::result_t reply_q [$];
    int unsigned mismatch_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned sent_items = 0;
    bit          rst_done = 1'b0;
    bit          no_idle = 1'b0;
    bit          hold_rx = 1'b0;

    function automatic agsr_pkg::result_t predict_reply(agsr_pkg::item_t it);
        agsr_pkg::result_t r;
        agsr_pkg::byte_t   pos;
        agsr_pkg::byte_t   half;
        logic              cfg_answer;
        pos = {4'd0, pad_pos};
        half = (pos - 8'd1) >> 1;
        cfg_answer = 1'b1;
        if (!it.req_type) begin
            pad_pos = 4'd0;
            r.rx_byte = agsr_pkg::ANS_IDLE;
        end else if (pad_pos == 4'd0) begin
            pad_cmd = regs.controller_is_analog ? it.tx_byte : agsr_pkg::CMD_READ;
            pad_pos = 4'd1;
            pad_len = 4'(FRAME_BYTES);
            case (pad_cmd)
                agsr_pkg::CMD_SET_MODE, agsr_pkg::CMD_TYPE_INFO: pad_frame = agsr_pkg::TAB_ZERO;
                agsr_pkg::CMD_MODEL_INFO: begin
                    pad_frame = agsr_pkg::TAB_MODEL;
                    pad_frame[4] = pad_analog;
                end
                agsr_pkg::CMD_ACT_INFO: pad_frame = agsr_pkg::TAB_ACT;
                agsr_pkg::CMD_COMB_INFO: pad_frame = agsr_pkg::TAB_COMB;
                agsr_pkg::CMD_VIB_MAP: pad_frame = agsr_pkg::TAB_VIB;
                agsr_pkg::CMD_CONFIG: begin
                    // outside config mode this is answered as a read
                    if (pad_cfg_mode != 8'h00) pad_frame = agsr_pkg::TAB_ZERO;
                    else cfg_answer = 1'b0;
                end
                default: cfg_answer = 1'b0;
            endcase
            if (cfg_answer) begin
                r.rx_byte = agsr_pkg::ANS_CONFIG;
            end else begin
                pad_frame[2] = it.buttons[7:0];
                pad_frame[3] = it.buttons[15:8];
                if (pad_analog == 8'h01) begin
                    pad_frame[4] = it.right_x;
                    pad_frame[5] = it.right_y;
                    pad_frame[6] = it.left_x;
                    pad_frame[7] = it.left_y;
                end else begin
                    pad_len = agsr_pkg::DIGITAL_LEN;
                end
                r.rx_byte = pad_ident;
            end
        end else if (pad_pos >= pad_len || pad_pos > 4'd7) begin
            r.rx_byte = agsr_pkg::ANS_IDLE;
        end else begin
            if (pad_pos == 4'd2) begin
                case (pad_cmd)
                    agsr_pkg::CMD_CONFIG: pad_cfg_mode = it.tx_byte;
                    agsr_pkg::CMD_SET_MODE: begin
                        pad_analog = it.tx_byte;
                        pad_ident = (it.tx_byte != 8'h00) ? agsr_pkg::ID_ANALOG
                                                          : agsr_pkg::ID_DIGITAL;
                    end
                    agsr_pkg::CMD_ACT_INFO: begin
                        if (it.tx_byte == 8'h00) begin
                            pad_frame[5] = 8'h02;
                            pad_frame[6] = 8'h00;
                            pad_frame[7] = 8'h0A;
                        end else if (it.tx_byte == 8'h01) begin
                            pad_frame[5] = 8'h01;
                            pad_frame[6] = 8'h01;
                            pad_frame[7] = 8'h14;
                        end
                    end
                    agsr_pkg::CMD_TYPE_INFO: begin
                        if (it.tx_byte == 8'h00) pad_frame[5] = regs.standard_type_code;
                        else if (it.tx_byte == 8'h01) pad_frame[5] = regs.analog_type_code;
                    end
                    default: ;
                endcase
            end
            if (regs.controller_is_analog) begin
                if (pad_cmd == agsr_pkg::CMD_READ) begin
                    for (int i = 0; i < 2; i++)
                        if (motor_slot[i] == pos) motor_lvl[i] = it.tx_byte;
                end else if (pad_cmd == agsr_pkg::CMD_VIB_MAP) begin
                    for (int i = 0; i < 2; i++)
                        if (motor_slot[i] == pos) pad_frame[pad_pos[2:0]] = 8'h00;
                    if (it.tx_byte < 8'd2) begin
                        motor_slot[it.tx_byte[0]] = pos;
                        if ({4'd0, pad_ident[3:0]} < half)
                            pad_ident = {pad_ident[7:4], half[3:0]};
                    end
                end
            end
            r.rx_byte = pad_frame[pad_pos[2:0]];
            pad_pos = pad_pos + 4'd1;
        end
        r.motor_level_a = motor_lvl[0];
        r.motor_level_b = motor_lvl[1];
        return r;
    endfunction

    function automatic agsr_pkg::item_t pad_item(logic req, agsr_pkg::byte_t tx);
        agsr_pkg::item_t it;
        it.req_type = req;
        it.tx_byte = tx;
        it.buttons = 16'($urandom);
        it.right_x = 8'($urandom);
        it.right_y = 8'($urandom);
        it.left_x = 8'($urandom);
        it.left_y = 8'($urandom);
        return it;
    endfunction

    // Offer one item, wait for accept, then the trailing gap. With a zero gap
    // s_valid stays high so the next call can follow in the same step.
    task automatic push_exchange(agsr_pkg::item_t it);
        int unsigned gap;
        s_valid <= 1'b1;
        s_req_type <= it.req_type;
        s_tx_byte <= it.tx_byte;
        s_buttons <= it.buttons;
        s_right_x <= it.right_x;
        s_right_y <= it.right_y;
        s_left_x <= it.left_x;
        s_left_y <= it.left_y;
        do @(posedge aclk); while (!s_ready);
        reply_q.push_back(predict_reply(it));
        sent_items++;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(logic analog, agsr_pkg::byte_t std_code,
                                  agsr_pkg::byte_t ana_code);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= agsr_pkg::REG_IS_ANALOG;
        cfg_wdata <= {7'd0, analog};
        @(posedge aclk);
        cfg_index <= agsr_pkg::REG_STD_TYPE;
        cfg_wdata <= std_code;
        @(posedge aclk);
        cfg_index <= agsr_pkg::REG_ANA_TYPE;
        cfg_wdata <= ana_code;
        @(posedge aclk);
        cfg_we <= 1'b0;
        regs.controller_is_analog = analog;
        regs.standard_type_code = std_code;
        regs.analog_type_code = ana_code;
    endtask

    task automatic send_frame(agsr_pkg::byte_t cmd, int unsigned n, agsr_pkg::byte_t d1,
                              agsr_pkg::byte_t d2, agsr_pkg::byte_t d3);
        agsr_pkg::byte_t data [3];
        data = '{d1, d2, d3};
        push_exchange(pad_item(1'b0, 8'h00));
        push_exchange(pad_item(1'b1, cmd));
        for (int k = 0; k < n; k++) push_exchange(pad_item(1'b1, data[k]));
    endtask

    // Mostly well-formed frames with random content; some lack the start
    // item or carry an unknown command.
    task automatic send_random_frame();
        agsr_pkg::byte_t cmd;
        agsr_pkg::byte_t tx;
        int unsigned     sel;
        int unsigned     n;
        sel = $urandom_range(0, 99);
        if (sel < 35) cmd = agsr_pkg::CMD_READ;
        else if (sel < 45) cmd = agsr_pkg::CMD_CONFIG;
        else if (sel < 51) cmd = agsr_pkg::CMD_SET_MODE;
        else if (sel < 56) cmd = agsr_pkg::CMD_MODEL_INFO;
        else if (sel < 63) cmd = agsr_pkg::CMD_ACT_INFO;
        else if (sel < 68) cmd = agsr_pkg::CMD_COMB_INFO;
        else if (sel < 76) cmd = agsr_pkg::CMD_TYPE_INFO;
        else if (sel < 90) cmd = agsr_pkg::CMD_VIB_MAP;
        else cmd = 8'($urandom);
        n = $urandom_range(1, 10);
        if ($urandom_range(0, 19) != 0) push_exchange(pad_item(1'b0, 8'($urandom)));
        push_exchange(pad_item(1'b1, cmd));
        for (int k = 1; k < n; k++) begin
            tx = 8'($urandom);
            if (k == 2 && $urandom_range(0, 3) != 0) begin
                tx = 8'($urandom_range(0, 1));
            end else if (cmd == agsr_pkg::CMD_VIB_MAP) begin
                case ($urandom_range(0, 3))
                    0: tx = 8'h00;
                    1: tx = 8'h01;
                    2: tx = agsr_pkg::SLOT_NONE;
                    default: ;
                endcase
            end
            push_exchange(pad_item(1'b1, tx));
        end
    endtask

    task automatic test_directed_frames();
        agsr_pkg::item_t it;
        // a byte with no start right after reset acts as byte 0
        it = pad_item(1'b1, agsr_pkg::CMD_READ);
        it.buttons = 16'hFFFF;
        {it.right_x, it.right_y, it.left_x, it.left_y} = 32'hFFFF_FFFF;
        push_exchange(it);
        // last one runs past the frame
        for (int k = 1; k <= 8; k++) push_exchange(pad_item(1'b1, 8'($urandom)));
        push_exchange(pad_item(1'b0, 8'hFF));
        it = pad_item(1'b1, agsr_pkg::CMD_READ);
        it.buttons = 16'h0000;
        {it.right_x, it.right_y, it.left_x, it.left_y} = 32'h0;
        push_exchange(it);
        // config command outside config mode: read answer, then enter
        send_frame(agsr_pkg::CMD_CONFIG, 2, 8'h00, 8'h01, 8'h00);
        // map both motors; slot value 7 maps no motor
        send_frame(agsr_pkg::CMD_VIB_MAP, 3, 8'h00, 8'h01, 8'h07);
        send_frame(agsr_pkg::CMD_CONFIG, 2, 8'h00, 8'h00, 8'h00);
        send_frame(agsr_pkg::CMD_READ, 2, 8'hFF, 8'h5C, 8'h00);
    endtask

    task automatic run_phase();
        int unsigned first;
        first = sent_items;
        while (sent_items - first < PHASE_ITEMS) send_random_frame();
    endtask

    task automatic test_register_settings();
        run_phase();
        apply_settings(1'b0, 8'h00, 8'hFF);
        run_phase();
        apply_settings(1'b1, 8'hFF, 8'h00);
        run_phase();
        apply_settings(1'b1, 8'($urandom), 8'($urandom));
        no_idle = 1'b1;
        run_phase();
        no_idle = 1'b0;
        apply_settings(1'b0, 8'($urandom), 8'($urandom));
        run_phase();
        apply_settings(1'b1, 8'h04, 8'h07);
        run_phase();
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_stall_fill();
        no_idle = 1'b1;
        hold_rx = 1'b1;
        repeat (12) send_random_frame();
        no_idle = 1'b0;
    endtask

    initial begin : result_sink
        int unsigned       stall;
        agsr_pkg::result_t want;
        while (!rst_done) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (hold_rx) begin
                hold_rx = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (reply_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected item: rx %02h motors %02h %02h",
                             m_rx_byte, m_motor_level_a, m_motor_level_b);
            end else begin
                want = reply_q.pop_front();
                if (m_rx_byte !== want.rx_byte || m_motor_level_a !== want.motor_level_a ||
                    m_motor_level_b !== want.motor_level_b) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: rx %02h/%02h motor_a %02h/%02h motor_b %02h/%02h",
                                 want.rx_byte, m_rx_byte, want.motor_level_a,
                                 m_motor_level_a, want.motor_level_b, m_motor_level_b);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("tb_analog_gamepad_serial_responder NOT OK");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        rst_done = 1'b1;
        test_directed_frames();
        test_register_settings();
        test_stall_fill();
        drain();
        repeat (4) @(posedge aclk);
        if (mismatch_cnt == 0 && reply_q.size() == 0) begin
            $display("tb_analog_gamepad_serial_responder OK");
        end else begin
            $display("tb_analog_gamepad_serial_responder NOT OK");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/agsr_pkg.sv
rtl/agsr_engine.sv
rtl/analog_gamepad_serial_responder.sv
sim/tb_analog_gamepad_serial_responder.sv
